[rtl/qpu_pkg.sv]
package qpu_pkg;

    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;
    localparam int INDEX_W    = 22;
    localparam int PIX_W      = 12;
    localparam int CNT_W      = 9;
    localparam int LIM_W      = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUADRANT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULE_PARITY = 2'd3;

    localparam logic [11:0] HEIGHT_RESET = 12'd512;
    localparam logic [11:0] WIDTH_RESET  = 12'd1024;
    localparam logic [10:0] CNT_LIMIT    = 11'd512;

    typedef struct packed {
        logic [11:0] height;
        logic [11:0] width;
        logic [1:0]  quadrant;
        logic        module_parity;
    } qpu_cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] group;
        logic             last;
    } qpu_pos_t;

    typedef struct packed {
        logic ld_in;
        logic ld_mul;
        logic ld_out;
    } qpu_adv_t;

    function automatic logic [LIM_W-1:0] clamp_count(input logic [10:0] v);
        logic [LIM_W-1:0] r;
        if (v == 11'd0) begin
            r = LIM_W'(1);
        end else if (v > CNT_LIMIT) begin
            r = CNT_LIMIT[LIM_W-1:0];
        end else begin
            r = v[LIM_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/quadrant_pixel_unpack_placer.sv]
// Channel   | Direction | Payload
// s_        | in        | tdata[23:0] packed_group
// m_        | out       | tdata[21:0] pixel_index, [33:22] first_pixel,
//           |           | [45:34] second_pixel, [47:46] zero; tlast last_of_frame
// cfg_      | in        | cfg_index register, cfg_data[11:0] value
//
// One request per cycle is sustained unless m_ stalls; every stage below is registered.
// Stages: input capture, two parallel multipliers (start row and row offset), index sum.
// Reset clears the frame counters, stage valids and config to 512 x 1024, quadrant SW.
// A stalled m_ side holds the result register; s_tready drops only when no stage can advance.
module quadrant_pixel_unpack_placer
    import qpu_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // packed_group
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // pixel_index, first_pixel, second_pixel
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    qpu_cfg_t cfg;
    qpu_pos_t pos;
    qpu_adv_t adv;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic adv1, adv2, adv3;

    logic [INDEX_W-1:0] pixel_index;
    logic [PIX_W-1:0]   first_pixel;
    logic [PIX_W-1:0]   second_pixel;

    always_comb begin
        adv3       = !v3_reg || m_tready;
        adv2       = !v2_reg || adv3;
        adv1       = !v1_reg || adv2;
        adv.ld_in  = s_tvalid && adv1;
        adv.ld_mul = v1_reg && adv2;
        adv.ld_out = v2_reg && adv3;
        v1_next    = adv.ld_in  ? 1'b1 : (adv.ld_mul ? 1'b0 : v1_reg);
        v2_next    = adv.ld_mul ? 1'b1 : (adv.ld_out ? 1'b0 : v2_reg);
        v3_next    = adv.ld_out ? 1'b1 : (m_tready   ? 1'b0 : v3_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    qpu_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    qpu_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (adv.ld_in),
        .pos     (pos)
    );

    qpu_place u_place (
        .aclk          (aclk),
        .cfg           (cfg),
        .adv           (adv),
        .packed_group  (s_tdata),
        .pos           (pos),
        .pixel_index   (pixel_index),
        .first_pixel   (first_pixel),
        .second_pixel  (second_pixel),
        .last_of_frame (m_tlast)
    );

    assign s_tready = adv1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = {2'b00, second_pixel, first_pixel, pixel_index};

endmodule

[rtl/qpu_cfg.sv]
module qpu_cfg
    import qpu_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output qpu_cfg_t              cfg
);

    logic [11:0] height_reg;
    logic [11:0] width_reg;
    logic [1:0]  quadrant_reg;
    logic        parity_reg;
    logic        wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg   <= HEIGHT_RESET;
            width_reg    <= WIDTH_RESET;
            quadrant_reg <= 2'd0;
            parity_reg   <= 1'b0;
        end else if (wr) begin
            case (cfg_index)
                CFG_IMAGE_HEIGHT:  height_reg   <= cfg_data[11:0];
                CFG_IMAGE_WIDTH:   width_reg    <= cfg_data[11:0];
                CFG_QUADRANT:      quadrant_reg <= cfg_data[1:0];
                CFG_MODULE_PARITY: parity_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.height        = (32'(height_reg) > MAX_HEIGHT) ? 12'(MAX_HEIGHT) : height_reg;
        cfg.width         = (32'(width_reg) > MAX_WIDTH) ? 12'(MAX_WIDTH) : width_reg;
        cfg.quadrant      = quadrant_reg;
        cfg.module_parity = parity_reg;
    end

endmodule

[rtl/qpu_scan.sv]
module qpu_scan
    import qpu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  qpu_cfg_t cfg,
    input  logic     advance,
    output qpu_pos_t pos
);

    logic [CNT_W-1:0] row_count_reg;
    logic [CNT_W-1:0] row_count_next;
    logic [CNT_W-1:0] group_count_reg;
    logic [CNT_W-1:0] group_count_next;
    logic [LIM_W-1:0] rows;
    logic [LIM_W-1:0] groups;
    logic [10:0]      half_groups;
    logic             last_group;
    logic             last_row;

    always_comb begin
        half_groups = 11'((12'(cfg.width >> 1) + 12'd1) >> 1);
        rows        = clamp_count(11'(cfg.height >> 2));
        groups      = clamp_count(half_groups);
        last_group  = (LIM_W'(group_count_reg) + LIM_W'(1)) >= groups;
        last_row    = (LIM_W'(row_count_reg) + LIM_W'(1)) >= rows;

        row_count_next   = row_count_reg;
        group_count_next = group_count_reg;
        if (advance) begin
            if (last_group) begin
                group_count_next = '0;
                row_count_next   = last_row ? '0 : row_count_reg + CNT_W'(1);
            end else begin
                group_count_next = group_count_reg + CNT_W'(1);
            end
        end

        pos.row   = row_count_reg;
        pos.group = group_count_reg;
        pos.last  = last_group && last_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg   <= '0;
            group_count_reg <= '0;
        end else begin
            row_count_reg   <= row_count_next;
            group_count_reg <= group_count_next;
        end
    end

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && pos.last |=> row_count_reg == '0 && group_count_reg == '0)
        else $error("counters did not wrap at frame end");

    a_group_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !last_group |=>
            group_count_reg == $past(group_count_reg) + CNT_W'(1) && $stable(row_count_reg))
        else $error("group counter did not step");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(row_count_reg) && $stable(group_count_reg))
        else $error("counters moved without a request");

endmodule

[rtl/qpu_place.sv]
module qpu_place
    import qpu_pkg::*;
(
    input  logic                 aclk,
    input  qpu_cfg_t             cfg,
    input  qpu_adv_t             adv,
    input  logic [IN_DATA_W-1:0] packed_group,
    input  qpu_pos_t             pos,
    output logic [INDEX_W-1:0]   pixel_index,
    output logic [PIX_W-1:0]     first_pixel,
    output logic [PIX_W-1:0]     second_pixel,
    output logic                 last_of_frame
);

    logic [PIX_W-1:0]   pix1_s1_reg;
    logic [PIX_W-1:0]   pix2_s1_reg;
    logic [CNT_W-1:0]   row_s1_reg;
    logic [CNT_W-1:0]   grp_s1_reg;
    logic               last_s1_reg;

    logic [PIX_W-1:0]   pix1_s2_reg;
    logic [PIX_W-1:0]   pix2_s2_reg;
    logic [CNT_W-1:0]   grp_s2_reg;
    logic               last_s2_reg;
    logic [INDEX_W-1:0] start_prod_reg;
    logic [20:0]        row_prod_reg;

    logic [INDEX_W-1:0] index_reg;
    logic [PIX_W-1:0]   pix1_s3_reg;
    logic [PIX_W-1:0]   pix2_s3_reg;
    logic               last_s3_reg;

    logic               north;
    logic [10:0]        base_rows;
    logic [INDEX_W-1:0] start_prod;
    logic [20:0]        row_prod;
    logic [INDEX_W-1:0] east_term;
    logic [INDEX_W-1:0] jump;
    logic [INDEX_W-1:0] base;
    logic [INDEX_W-1:0] index_next;

    assign north = cfg.quadrant[1];

    always_comb begin
        if (cfg.height == 12'd0) begin
            base_rows = '0;
        end else if (north) begin
            base_rows = 11'((cfg.height - 12'd1) >> 1);
        end else begin
            base_rows = 11'(cfg.height >> 1);
        end
        start_prod = INDEX_W'(base_rows) * INDEX_W'(cfg.width);
        row_prod   = 21'(cfg.width) * 21'(row_s1_reg);
    end

    always_comb begin
        east_term  = cfg.quadrant[0] ? INDEX_W'(cfg.width >> 1) : '0;
        jump       = (cfg.module_parity ? '0 : INDEX_W'(cfg.width)) + {row_prod_reg, 1'b0};
        base       = start_prod_reg + east_term + INDEX_W'({grp_s2_reg, 1'b0});
        index_next = north ? base - jump : base + jump;
    end

    always_ff @(posedge aclk) begin
        if (adv.ld_in) begin
            pix1_s1_reg <= {packed_group[7:0], packed_group[15:12]};
            pix2_s1_reg <= {packed_group[11:8], packed_group[23:16]};
            row_s1_reg  <= pos.row;
            grp_s1_reg  <= pos.group;
            last_s1_reg <= pos.last;
        end
        if (adv.ld_mul) begin
            pix1_s2_reg    <= pix1_s1_reg;
            pix2_s2_reg    <= pix2_s1_reg;
            grp_s2_reg     <= grp_s1_reg;
            last_s2_reg    <= last_s1_reg;
            start_prod_reg <= start_prod;
            row_prod_reg   <= row_prod;
        end
        if (adv.ld_out) begin
            index_reg   <= index_next;
            pix1_s3_reg <= pix1_s2_reg;
            pix2_s3_reg <= pix2_s2_reg;
            last_s3_reg <= last_s2_reg;
        end
    end

    assign pixel_index   = index_reg;
    assign first_pixel   = pix1_s3_reg;
    assign second_pixel  = pix2_s3_reg;
    assign last_of_frame = last_s3_reg;

endmodule
